// ===== src/tlshd_pkg.sv =====
// tlshd_pkg: shared types, codes and widths of the TLS handshake deframer.
// No dependencies; used by every module under src.
package tlshd_pkg;

    localparam int BYTE_W        = 8;
    localparam int MSG_LEN_W     = 24;
    localparam int LENGTH_BITS_D = 24;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_HS_REC_TYPE  = 2'd0;
    localparam logic [1:0] REG_CCS_REC_TYPE = 2'd1;
    localparam logic [1:0] REG_CCS_MSG_TYPE = 2'd2;

    localparam logic [7:0] HS_REC_TYPE_RST  = 8'd22;
    localparam logic [7:0] CCS_REC_TYPE_RST = 8'd20;
    localparam logic [7:0] CCS_MSG_TYPE_RST = 8'd254;

    // result kinds
    localparam logic [1:0] KIND_BODY    = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_BAD_CCS = 2'd2;
    localparam logic [1:0] KIND_BAD_REC = 2'd3;

    // stream operations from the front end to the parser
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_BAD_CCS = 2'd1;
    localparam logic [1:0] OP_BAD_REC = 2'd2;

    // ccs record progress
    localparam logic [1:0] CCS_NONE = 2'd0;
    localparam logic [1:0] CCS_ONE  = 2'd1;
    localparam logic [1:0] CCS_BAD  = 2'd2;

    typedef struct packed {
        logic [7:0] hs_rec_type;
        logic [7:0] ccs_rec_type;
        logic [7:0] ccs_msg_type;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        code;
        logic [BYTE_W-1:0] data;
    } op_t;

    typedef struct packed {
        logic fault;
        logic inj_busy;
    } front_stat_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [BYTE_W-1:0]    msg_type;
        logic [MSG_LEN_W-1:0] msg_length;
        logic [BYTE_W-1:0]    payload;
        logic                 last;
    } res_t;

endpackage

// ===== src/tlshd_front.sv =====
// tlshd_front: record classification, CCS check, pseudo-header injection, op register.
// Depends on tlshd_pkg.
module tlshd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tlshd_pkg::cfg_t       cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_rec_type,
    input  logic                  in_has_byte,
    input  logic [7:0]            in_data,
    input  logic                  in_last,
    output logic                  op_valid,
    output tlshd_pkg::op_t        op,
    input  logic                  op_ready,
    output tlshd_pkg::front_stat_t stat
);

    logic            op_valid_reg, op_valid_next;
    tlshd_pkg::op_t  op_reg, op_next;
    logic [1:0]      inj_cnt_reg, inj_cnt_next;
    logic [1:0]      ccs_seen_reg, ccs_seen_next;
    logic            fault_reg, fault_next;
    logic [1:0]      seen_upd;
    logic            advance;
    logic            take;

    assign advance  = !op_valid_reg || op_ready;
    assign in_ready = advance && (inj_cnt_reg == 2'd0);
    assign take     = in_valid && in_ready;

    always_comb begin
        seen_upd = ccs_seen_reg;
        if (in_has_byte) begin
            seen_upd = (ccs_seen_reg == tlshd_pkg::CCS_NONE && in_data == 8'd1)
                       ? tlshd_pkg::CCS_ONE : tlshd_pkg::CCS_BAD;
        end
    end

    always_comb begin
        op_valid_next = op_valid_reg;
        op_next       = op_reg;
        inj_cnt_next  = inj_cnt_reg;
        ccs_seen_next = ccs_seen_reg;
        fault_next    = fault_reg;
        if (advance) begin
            op_valid_next = 1'b0;
            op_next.code  = tlshd_pkg::OP_BYTE;
            op_next.data  = '0;
            if (inj_cnt_reg != 2'd0) begin
                // remaining zero bytes of the injected pseudo-header
                op_valid_next = 1'b1;
                inj_cnt_next  = inj_cnt_reg - 2'd1;
            end else if (take && !fault_reg) begin
                if (in_rec_type == cfg.hs_rec_type) begin
                    op_valid_next = in_has_byte;
                    op_next.data  = in_data;
                end else if (in_rec_type == cfg.ccs_rec_type) begin
                    ccs_seen_next = seen_upd;
                    if (in_last) begin
                        ccs_seen_next = tlshd_pkg::CCS_NONE;
                        op_valid_next = 1'b1;
                        if (seen_upd == tlshd_pkg::CCS_ONE) begin
                            op_next.data = cfg.ccs_msg_type;
                            inj_cnt_next = 2'd3;
                        end else begin
                            op_next.code = tlshd_pkg::OP_BAD_CCS;
                            fault_next   = 1'b1;
                        end
                    end
                end else begin
                    op_valid_next = 1'b1;
                    op_next.code  = tlshd_pkg::OP_BAD_REC;
                    fault_next    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg <= 1'b0;
            inj_cnt_reg  <= 2'd0;
            ccs_seen_reg <= tlshd_pkg::CCS_NONE;
            fault_reg    <= 1'b0;
        end else begin
            op_valid_reg <= op_valid_next;
            inj_cnt_reg  <= inj_cnt_next;
            ccs_seen_reg <= ccs_seen_next;
            fault_reg    <= fault_next;
        end
        op_reg <= op_next;
    end

    assign op_valid      = op_valid_reg;
    assign op            = op_reg;
    assign stat.fault    = fault_reg;
    assign stat.inj_busy = (inj_cnt_reg != 2'd0);

endmodule

// ===== src/tlshd_parser.sv =====
// tlshd_parser: message header parser over the byte stream, with the result register.
// Depends on tlshd_pkg.
module tlshd_parser #(
    parameter int LENGTH_BITS = tlshd_pkg::LENGTH_BITS_D
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            op_valid,
    input  tlshd_pkg::op_t  op,
    output logic            op_ready,
    output logic            res_valid,
    output tlshd_pkg::res_t res,
    input  logic            res_ready
);

    localparam logic [2:0] PH_TYPE = 3'd0;
    localparam logic [2:0] PH_LEN1 = 3'd1;
    localparam logic [2:0] PH_LEN2 = 3'd2;
    localparam logic [2:0] PH_LEN3 = 3'd3;
    localparam logic [2:0] PH_BODY = 3'd4;

    logic [2:0]             phase_reg, phase_next;
    logic [7:0]             type_reg, type_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic                   out_valid_reg, out_valid_next;
    tlshd_pkg::res_t        out_reg, out_next;
    logic [LENGTH_BITS+7:0] len_shift;
    logic                   out_free;
    logic                   go;
    logic                   emit;
    tlshd_pkg::res_t        r;

    assign out_free  = !out_valid_reg || res_ready;
    assign op_ready  = out_free;
    assign go        = op_valid && out_free;
    assign len_shift = {len_reg, op.data};

    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        emit       = 1'b0;
        r          = '0;
        case (op.code)
            tlshd_pkg::OP_BAD_CCS: begin
                emit   = 1'b1;
                r.kind = tlshd_pkg::KIND_BAD_CCS;
            end
            tlshd_pkg::OP_BAD_REC: begin
                emit   = 1'b1;
                r.kind = tlshd_pkg::KIND_BAD_REC;
            end
            tlshd_pkg::OP_BYTE: begin
                case (phase_reg)
                    PH_LEN1, PH_LEN2: begin
                        len_next   = len_shift[LENGTH_BITS-1:0];
                        phase_next = phase_reg + 3'd1;
                    end
                    PH_LEN3: begin
                        len_next = len_shift[LENGTH_BITS-1:0];
                        if (len_shift[LENGTH_BITS-1:0] == '0) begin
                            emit       = 1'b1;
                            r.kind     = tlshd_pkg::KIND_EMPTY;
                            r.msg_type = type_reg;
                            r.last     = 1'b1;
                            phase_next = PH_TYPE;
                        end else begin
                            left_next  = len_shift[LENGTH_BITS-1:0];
                            phase_next = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        left_next    = left_reg - LENGTH_BITS'(1);
                        emit         = 1'b1;
                        r.kind       = tlshd_pkg::KIND_BODY;
                        r.msg_type   = type_reg;
                        r.msg_length = tlshd_pkg::MSG_LEN_W'(len_reg);
                        r.payload    = op.data;
                        r.last       = (left_reg == LENGTH_BITS'(1));
                        if (left_reg == LENGTH_BITS'(1)) begin
                            phase_next = PH_TYPE;
                        end
                    end
                    default: begin
                        // type byte; unused phase codes behave the same
                        type_next  = op.data;
                        len_next   = '0;
                        left_next  = '0;
                        phase_next = PH_LEN1;
                    end
                endcase
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free) begin
            out_valid_next = go && emit;
            out_next       = r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TYPE;
            type_reg      <= '0;
            len_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (go) begin
                phase_reg <= phase_next;
                type_reg  <= type_next;
                len_reg   <= len_next;
                left_reg  <= left_next;
            end
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// ===== src/tls_handshake_deframer.sv =====
// tls_handshake_deframer: top level; APB register file, front end and header parser.
// Depends on tlshd_pkg, tlshd_front, tlshd_parser.
//
//  port group | dir | tdata              | tuser                       | tlast
//  s_*        | in  | [7:0] data_byte    | [7:0] record_type, [8] has  | last_of_record
//  m_*        | out | [23:0] msg_length, | [1:0] kind, [9:2] msg_type  | last_of_message
//             |     | [31:24] payload    |                             |
//  p*         | in  | APB, regs at 0x0 handshake type, 0x4 ccs type, 0x8 ccs msg type
//
// One beat per cycle while nothing holds s_tready low, through an op register and a result register.
// The closing beat of a valid ChangeCipherSpec record holds s_tready low while the
// injection counter feeds the three pseudo-header zero bytes to the parser.
// A stalled m_ side stops the parser, then the op register, then s_tready.
// Reset is synchronous and needs no clearing pass; an error sets a fault until reset.
module tls_handshake_deframer #(
    parameter int LENGTH_BITS = tlshd_pkg::LENGTH_BITS_D
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [7:0] data_byte
    input  logic [8:0]                       s_tuser,  // [7:0] record_type, [8] has_byte
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,  // [23:0] msg_length, [31:24] payload
    output logic [9:0]                       m_tuser,  // [1:0] kind, [9:2] msg_type
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tlshd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tlshd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tlshd_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);

    tlshd_pkg::cfg_t        cfg_reg;
    tlshd_pkg::op_t         op;
    tlshd_pkg::res_t        res;
    tlshd_pkg::front_stat_t stat;
    logic                   op_valid;
    logic                   op_ready;
    logic                   cfg_wr;
    logic [1:0]             reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hs_rec_type  <= tlshd_pkg::HS_REC_TYPE_RST;
            cfg_reg.ccs_rec_type <= tlshd_pkg::CCS_REC_TYPE_RST;
            cfg_reg.ccs_msg_type <= tlshd_pkg::CCS_MSG_TYPE_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                tlshd_pkg::REG_HS_REC_TYPE:  cfg_reg.hs_rec_type  <= pwdata[7:0];
                tlshd_pkg::REG_CCS_REC_TYPE: cfg_reg.ccs_rec_type <= pwdata[7:0];
                tlshd_pkg::REG_CCS_MSG_TYPE: cfg_reg.ccs_msg_type <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tlshd_pkg::REG_HS_REC_TYPE:  prdata = {24'd0, cfg_reg.hs_rec_type};
            tlshd_pkg::REG_CCS_REC_TYPE: prdata = {24'd0, cfg_reg.ccs_rec_type};
            tlshd_pkg::REG_CCS_MSG_TYPE: prdata = {24'd0, cfg_reg.ccs_msg_type};
            default:                     prdata = '0;
        endcase
    end

    tlshd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_rec_type (s_tuser[7:0]),
        .in_has_byte (s_tuser[8]),
        .in_data     (s_tdata),
        .in_last     (s_tlast),
        .op_valid    (op_valid),
        .op          (op),
        .op_ready    (op_ready),
        .stat        (stat)
    );

    tlshd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (op_valid),
        .op        (op),
        .op_ready  (op_ready),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {res.payload, res.msg_length};
    assign m_tuser = {res.msg_type, res.kind};
    assign m_tlast = res.last;

`ifndef SYNTHESIS
    // the fault stays set until reset
    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.fault |=> stat.fault)
        else $error("fault flag cleared without reset");

    // no new beat while pseudo-header bytes are still being injected
    a_inject_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.inj_busy |-> !s_tready)
        else $error("input accepted during ccs injection");

    // an error result can only follow a latched fault
    a_err_has_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> stat.fault)
        else $error("error result without fault");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for tls_handshake_deframer; streams record beats in, checks results.
// Depends on tlshd_pkg and the RTL under src; nothing else is read.
module tb;

    localparam int QUIET_LIMIT   = 2000;  // cycles with no beat, write or read
    localparam int SETTLE_CYCLES = 8;     // covers the op and result registers plus the CCS injection
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE_BEATS   = 40;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [7:0]                       s_tdata;   // [7:0] data_byte
    logic [8:0]                       s_tuser;   // [7:0] record_type, [8] has_byte
    logic                             s_tlast;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [31:0]                      m_tdata;   // [23:0] msg_length, [31:24] payload_byte
    logic [9:0]                       m_tuser;   // [1:0] kind, [9:2] msg_type
    logic                             m_tlast;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [tlshd_pkg::APB_ADDR_W-1:0] paddr;
    logic [tlshd_pkg::APB_DATA_W-1:0] pwdata;
    logic [tlshd_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    // predictor copy of the registers and the parser state
    logic [7:0]  hs_type_q;
    logic [7:0]  ccs_type_q;
    logic [7:0]  ccs_msg_q;
    logic [2:0]  hdr_phase;   // 0 type byte, 1..3 length bytes, 4 body
    logic [7:0]  cur_type;
    logic [23:0] decl_len;
    logic [23:0] left_len;
    logic [1:0]  ccs_seen;
    logic        faulted;
    tlshd_pkg::res_t deframed_q[$];

    int errors       = 0;
    int quiet_cycles = 0;
    int beats_sent   = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;

    tls_handshake_deframer u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 50)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    function automatic void emit_result(input logic [1:0] kind, input logic [7:0] mtype,
                                        input logic [23:0] len, input logic [7:0] pay,
                                        input logic last);
        tlshd_pkg::res_t r;
        r.kind       = kind;
        r.msg_type   = mtype;
        r.msg_length = len;
        r.payload    = pay;
        r.last       = last;
        deframed_q.push_back(r);
    endfunction

    function automatic void stream_byte(input logic [7:0] b);
        if (hdr_phase >= 3'd1 && hdr_phase <= 3'd3) begin
            decl_len  = {decl_len[15:0], b};
            hdr_phase = hdr_phase + 3'd1;
            if (hdr_phase == 3'd4) begin
                if (decl_len == 24'd0) begin
                    emit_result(tlshd_pkg::KIND_EMPTY, cur_type, 24'd0, 8'd0, 1'b1);
                    hdr_phase = 3'd0;
                end else begin
                    left_len = decl_len;
                end
            end
        end else if (hdr_phase == 3'd4) begin
            left_len = left_len - 24'd1;
            emit_result(tlshd_pkg::KIND_BODY, cur_type, decl_len, b, left_len == 24'd0);
            if (left_len == 24'd0)
                hdr_phase = 3'd0;
        end else begin
            cur_type  = b;
            decl_len  = 24'd0;
            left_len  = 24'd0;
            hdr_phase = 3'd1;
        end
    endfunction

    function automatic void deframe_item(input logic [7:0] rtype, input logic has,
                                         input logic [7:0] data, input logic last);
        if (faulted)
            return;
        if (rtype == hs_type_q) begin
            if (has)
                stream_byte(data);
        end else if (rtype == ccs_type_q) begin
            if (has)
                ccs_seen = (ccs_seen == tlshd_pkg::CCS_NONE && data == 8'd1)
                           ? tlshd_pkg::CCS_ONE : tlshd_pkg::CCS_BAD;
            if (last) begin
                if (ccs_seen == tlshd_pkg::CCS_ONE) begin
                    stream_byte(ccs_msg_q);
                    stream_byte(8'd0);
                    stream_byte(8'd0);
                    stream_byte(8'd0);
                end else begin
                    faulted = 1'b1;
                    emit_result(tlshd_pkg::KIND_BAD_CCS, 8'd0, 24'd0, 8'd0, 1'b0);
                end
                ccs_seen = tlshd_pkg::CCS_NONE;
            end
        end else begin
            faulted = 1'b1;
            emit_result(tlshd_pkg::KIND_BAD_REC, 8'd0, 24'd0, 8'd0, 1'b0);
        end
    endfunction

    task automatic send_beat(input logic [7:0] rtype, input logic has,
                             input logic [7:0] data, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(255));
            s_tuser  <= 9'($urandom_range(511));
            s_tlast  <= 1'($urandom_range(1));
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= {has, rtype};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        beats_sent++;
        deframe_item(rtype, has, data, last);
    endtask

    // last_of_record means nothing on handshake beats, so it is left random
    task automatic send_hs(input logic [7:0] b);
        send_beat(hs_type_q, 1'b1, b, 1'($urandom_range(1)));
    endtask

    // writes all three registers once the block is idle, reading each one back
    task automatic apply_config(input logic [7:0] hs, input logic [7:0] ccs,
                                input logic [7:0] msg);
        logic [1:0] regs[3];
        logic [7:0] vals[3];
        int i;
        regs = '{tlshd_pkg::REG_HS_REC_TYPE, tlshd_pkg::REG_CCS_REC_TYPE,
                 tlshd_pkg::REG_CCS_MSG_TYPE};
        vals = '{hs, ccs, msg};
        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        for (i = 0; i < 3; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {regs[i], 2'b00};
            pwdata  <= {24'd0, vals[i]};
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready)
                @(posedge aclk);
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready)
                @(posedge aclk);
            if (prdata !== {24'd0, vals[i]})
                report_mismatch($sformatf("register %0d reads %h, wrote %h",
                                          regs[i], prdata, vals[i]));
            case (regs[i])
                tlshd_pkg::REG_HS_REC_TYPE:  hs_type_q  = vals[i];
                tlshd_pkg::REG_CCS_REC_TYPE: ccs_type_q = vals[i];
                default:                     ccs_msg_q  = vals[i];
            endcase
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // well-formed CCS record, sometimes padded with empty beats or split by handshake beats
    task automatic send_good_ccs();
        int pads;
        int i;
        pads = $urandom_range(2);
        for (i = 0; i < pads; i++) begin
            if ($urandom_range(2) == 0)
                send_beat(hs_type_q, 1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
            else
                send_beat(ccs_type_q, 1'b0, 8'($urandom_range(255)), 1'b0);
        end
        if ($urandom_range(1)) begin
            send_beat(ccs_type_q, 1'b1, 8'h01, 1'b1);
        end else begin
            send_beat(ccs_type_q, 1'b1, 8'h01, 1'b0);
            send_beat(ccs_type_q, 1'b0, 8'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic send_random_message();
        int len;
        int i;
        logic [31:0] hdr_word;
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
        hdr_word = {8'($urandom_range(255)), 24'd0} | 32'(len);
        for (i = 0; i < 4 + len; i++) begin
            if ($urandom_range(24) == 0)
                send_good_ccs();
            if ($urandom_range(15) == 0)
                send_beat(hs_type_q, 1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
            if (i < 4)
                send_hs(hdr_word[31 - 8*i -: 8]);
            else
                send_hs(8'($urandom_range(255)));
        end
    endtask

    task automatic test_reset_defaults();
        // type 0xFF, length 2, body 00 FF under the reset register values
        send_hs(8'hFF);
        send_hs(8'h00);
        send_hs(8'h00);
        send_hs(8'h02);
        send_hs(8'h00);
        send_hs(8'hFF);
    endtask

    task automatic test_ccs_injection();
        // padded CCS at a message boundary: pseudo-header alone, one empty message
        send_beat(ccs_type_q, 1'b0, 8'h00, 1'b0);
        send_beat(ccs_type_q, 1'b1, 8'h01, 1'b0);
        send_beat(ccs_type_q, 1'b0, 8'hFF, 1'b1);
        // CCS inside a body: its four bytes finish a five-byte message
        send_hs(8'h10);
        send_hs(8'h00);
        send_hs(8'h00);
        send_hs(8'h05);
        send_hs(8'hC3);
        send_beat(ccs_type_q, 1'b1, 8'h01, 1'b1);
        // handshake beats while a CCS record is still open
        send_beat(ccs_type_q, 1'b1, 8'h01, 1'b0);
        send_hs(8'h20);
        send_beat(hs_type_q, 1'b0, 8'h55, 1'b1);
        send_hs(8'h00);
        send_hs(8'h00);
        send_hs(8'h00);
        send_beat(ccs_type_q, 1'b0, 8'h00, 1'b1);
    endtask

    task automatic test_register_extremes();
        apply_config(8'h00, 8'hFF, 8'h00);
        send_beat(8'hFF, 1'b1, 8'h01, 1'b1);
        apply_config(8'hFF, 8'h00, 8'hFF);
        send_beat(8'h00, 1'b1, 8'h01, 1'b1);
        // equal types: handshake wins, so 01 00 00 00 is an ordinary empty message
        apply_config(8'h5A, 8'h5A, 8'h33);
        send_beat(8'h5A, 1'b1, 8'h01, 1'b1);
        send_beat(8'h5A, 1'b1, 8'h00, 1'b1);
        send_beat(8'h5A, 1'b1, 8'h00, 1'b1);
        send_beat(8'h5A, 1'b1, 8'h00, 1'b1);
    endtask

    task automatic test_random_streams();
        int phase_idle[4];
        int phase_stall[4];
        int p;
        int start;
        logic [7:0] hs;
        phase_idle  = '{0, 64, 0, 11};
        phase_stall = '{0, 0, 64, 11};
        for (p = 0; p < 4; p++) begin
            hs = 8'($urandom_range(255));
            apply_config(hs, ($urandom_range(3) == 0) ? hs : 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            start     = beats_sent;
            while (beats_sent - start < PHASE_BEATS)
                send_random_message();
        end
    endtask

    // must run last: the fault holds until reset
    task automatic test_sticky_fault();
        logic [7:0] hs;
        logic [7:0] ccs;
        logic [7:0] rt;
        logic [7:0] bad;
        hs  = 8'($urandom_range(255));
        ccs = hs + 8'($urandom_range(255, 1));
        apply_config(hs, ccs, 8'($urandom_range(255)));
        // header with the largest length, left open
        send_hs(8'($urandom_range(255)));
        send_hs(8'hFF);
        send_hs(8'hFF);
        send_hs(8'hFF);
        send_hs(8'($urandom_range(255)));
        send_hs(8'($urandom_range(255)));
        if ($urandom_range(1)) begin
            do rt = 8'($urandom_range(255)); while (rt == hs || rt == ccs);
            send_beat(rt, 1'($urandom_range(1)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
        end else begin
            case ($urandom_range(2))
                0: begin
                    do bad = 8'($urandom_range(255)); while (bad == 8'h01);
                    send_beat(ccs, 1'b1, bad, 1'b1);
                end
                1: begin
                    send_beat(ccs, 1'b1, 8'h01, 1'b0);
                    send_beat(ccs, 1'b1, 8'h01, 1'b1);
                end
                default: send_beat(ccs, 1'b0, 8'($urandom_range(255)), 1'b1);
            endcase
        end
        repeat (6)
            send_beat(8'($urandom_range(255)), 1'($urandom_range(1)),
                      8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin : check_results
        tlshd_pkg::res_t got;
        tlshd_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind       = m_tuser[1:0];
            got.msg_type   = m_tuser[9:2];
            got.msg_length = m_tdata[23:0];
            got.payload    = m_tdata[31:24];
            got.last       = m_tlast;
            if (deframed_q.size() == 0) begin
                report_mismatch($sformatf(
                    "unexpected beat kind %0d type %h len %h byte %h last %b",
                    got.kind, got.msg_type, got.msg_length, got.payload, got.last));
            end else begin
                want = deframed_q.pop_front();
                if (got.kind !== want.kind || got.msg_type !== want.msg_type
                    || got.msg_length !== want.msg_length || got.payload !== want.payload
                    || got.last !== want.last)
                    report_mismatch($sformatf(
                        "got kind %0d type %h len %h byte %h last %b, want %0d %h %h %h %b",
                        got.kind, got.msg_type, got.msg_length, got.payload, got.last,
                        want.kind, want.msg_type, want.msg_length, want.payload,
                        want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, deframed_q.size());
            $display("** tls_handshake_deframer: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        s_tlast    <= 1'b0;
        m_tready   <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        aresetn    <= 1'b0;
        hs_type_q  = tlshd_pkg::HS_REC_TYPE_RST;
        ccs_type_q = tlshd_pkg::CCS_REC_TYPE_RST;
        ccs_msg_q  = tlshd_pkg::CCS_MSG_TYPE_RST;
        hdr_phase  = 3'd0;
        cur_type   = 8'd0;
        decl_len   = 24'd0;
        left_len   = 24'd0;
        ccs_seen   = tlshd_pkg::CCS_NONE;
        faulted    = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_ccs_injection();
        test_register_extremes();
        test_random_streams();
        test_sticky_fault();

        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("** tls_handshake_deframer: PASSED **");
        else
            $display("** tls_handshake_deframer: FAILED **");
        $finish;
    end

endmodule
